### rtl/core/aalr_pkg.sv
// shared types and constants of the antialiased line rasterizer
package aalr_pkg;

	localparam int PIX_W         = 8;
	localparam int LEVEL_W       = 9;
	localparam int LEVEL_FRAC_W  = 8;
	localparam int LEVEL_FULL    = 256;
	localparam int MAX_PAIRS     = 64;
	localparam int PAIR_CNT_W    = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_pair;
	} dp_status_t;

endpackage

### rtl/core/antialiased_line_rasterizer.sv
// top level of the antialiased line rasterizer
// A segment is taken when start is high while busy is low, and its endpoints are captured at
// that edge. A setup state then orders them and sets up the divider, then the bit-serial
// gradient divider runs. After that one pixel pair comes out per cycle, each shown for one
// cycle with valid high, up to 64 pairs, the final one flagged by last. Busy stays high
// through setup, divide and emission; it drops as the last pair is shown, so the next
// segment can be taken in that same cycle. The receiver cannot stall: every pair must
// be taken in the cycle that it is shown.
module antialiased_line_rasterizer #(
	parameter int GRID_BITS              = 6,
	parameter int SUBPIXEL_BITS          = 4,
	parameter int GRADIENT_FRACTION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0] start_x,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0] start_y,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0] end_x,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0] end_y,
	output logic                               valid,
	output logic signed [aalr_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [aalr_pkg::PIX_W-1:0]  pixel_y,
	output logic                               steep,
	output logic [aalr_pkg::LEVEL_W-1:0]       first_level,
	output logic [aalr_pkg::LEVEL_W-1:0]       second_level,
	output logic                               last
);
	import aalr_pkg::*;

	localparam int DIV_STEPS = GRID_BITS + SUBPIXEL_BITS + GRADIENT_FRACTION_BITS;

	dp_cmd_t    cmd;
	dp_status_t status;

	aalr_ctrl #(
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	aalr_datapath #(
		.GRID_BITS              (GRID_BITS),
		.SUBPIXEL_BITS          (SUBPIXEL_BITS),
		.GRADIENT_FRACTION_BITS (GRADIENT_FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.valid        (valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.steep        (steep),
		.first_level  (first_level),
		.second_level (second_level),
		.last         (last)
	);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
	a_valid_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result word outside a segment");
	a_fall_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (valid && last))
		else $error("busy dropped without the last pair");
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("result word right after the last pair");

endmodule

### rtl/core/aalr_ctrl.sv
// sequencer for the line rasterizer: setup, serial divide, pair emission
module aalr_ctrl #(
	parameter int DIV_STEPS = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output aalr_pkg::dp_cmd_t    cmd,
	input  aalr_pkg::dp_status_t status
);
	import aalr_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				cnt_d     = '0;
				state_d   = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.last_pair) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> state_q == ST_EMIT)
		else $error("divide phase did not hand over to emission");
	a_setup_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |=> (state_q == ST_DIVIDE && cnt_q == '0))
		else $error("setup did not start the divider count");
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && status.last_pair) |=> state_q == ST_IDLE)
		else $error("emission ran past the last pair");

endmodule

### rtl/core/aalr_datapath.sv
// datapath: endpoint ordering, bit-serial gradient divider, minor accumulator and result words
module aalr_datapath #(
	parameter int GRID_BITS              = 6,
	parameter int SUBPIXEL_BITS          = 4,
	parameter int GRADIENT_FRACTION_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  aalr_pkg::dp_cmd_t                        cmd,
	output aalr_pkg::dp_status_t                     status,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0]       start_x,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0]       start_y,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0]       end_x,
	input  logic [GRID_BITS+SUBPIXEL_BITS-1:0]       end_y,
	output logic                                     valid,
	output logic signed [aalr_pkg::PIX_W-1:0]        pixel_x,
	output logic signed [aalr_pkg::PIX_W-1:0]        pixel_y,
	output logic                                     steep,
	output logic [aalr_pkg::LEVEL_W-1:0]             first_level,
	output logic [aalr_pkg::LEVEL_W-1:0]             second_level,
	output logic                                     last
);
	import aalr_pkg::*;

	localparam int GFB       = GRADIENT_FRACTION_BITS;
	localparam int COORD_W   = GRID_BITS + SUBPIXEL_BITS;
	localparam int MAJ_W     = GRID_BITS + 1;
	localparam int INT_W     = GRID_BITS + 2;
	localparam int ACC_W     = INT_W + GFB;
	localparam int GRAD_W    = GFB + 2;
	localparam int DIV_W     = COORD_W + GFB;
	localparam int MIN_SHIFT = GFB - SUBPIXEL_BITS;
	localparam int HALF      = (1 << SUBPIXEL_BITS) >> 1;

	// captured endpoints
	logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;

	// per-segment registers
	logic                     steep_q, neg_q, dzero_q;
	logic [COORD_W-1:0]       dmaj_q;
	logic [DIV_W-1:0]         num_q;
	logic [COORD_W-1:0]       rem_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MAJ_W-1:0]         m_q, mend_q;
	logic [PAIR_CNT_W-1:0]    n_q;

	// setup logic
	logic signed [COORD_W:0]  dx, dy;
	logic [COORD_W-1:0]       adx, ady;
	logic                     steep_c, swap_c;
	logic [COORD_W-1:0]       a0, a1, b0, b1;
	logic [COORD_W-1:0]       maj0, maj1, min0, min1;
	logic [COORD_W-1:0]       dmaj_c, dmin_abs;
	logic [COORD_W:0]         rsum0, rsum1;

	assign dx  = $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
	assign dy  = $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
	assign adx = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
	assign ady = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
	assign steep_c = adx < ady;
	assign swap_c  = steep_c ? (sy_q > ey_q) : (sx_q > ex_q);

	always_comb begin
		if (steep_c) begin
			a0 = sy_q;
			a1 = ey_q;
			b0 = sx_q;
			b1 = ex_q;
		end else begin
			a0 = sx_q;
			a1 = ex_q;
			b0 = sy_q;
			b1 = ey_q;
		end
		if (swap_c) begin
			maj0 = a1;
			maj1 = a0;
			min0 = b1;
			min1 = b0;
		end else begin
			maj0 = a0;
			maj1 = a1;
			min0 = b0;
			min1 = b1;
		end
	end

	assign dmaj_c   = steep_c ? ady : adx;
	assign dmin_abs = steep_c ? adx : ady;

	// round half up on the major coordinate
	assign rsum0 = {1'b0, maj0} + (COORD_W+1)'(HALF);
	assign rsum1 = {1'b0, maj1} + (COORD_W+1)'(HALF);

	// restoring divider: one quotient bit per cycle, quotient shifts into num_q
	logic [COORD_W:0] trial, trial_diff;
	logic             trial_ge;

	assign trial      = {rem_q, num_q[DIV_W-1]};
	assign trial_ge   = trial >= {1'b0, dmaj_q};
	assign trial_diff = trial - {1'b0, dmaj_q};

	// gradient and current pair
	logic [GRAD_W-1:0]        mag;
	logic signed [GRAD_W-1:0] grad;
	logic signed [INT_W-1:0]  int_part;
	logic [LEVEL_FRAC_W-1:0]  frac8;
	logic signed [PIX_W-1:0]  minor_pix, major_pix;
	logic                     last_c;

	assign mag       = {1'b0, num_q[GFB:0]};
	assign grad      = dzero_q ? '0 : (neg_q ? -$signed(mag) : $signed(mag));
	assign int_part  = acc_q[ACC_W-1:GFB];
	assign frac8     = acc_q[GFB-1 -: LEVEL_FRAC_W];
	assign minor_pix = PIX_W'(int_part);
	assign major_pix = PIX_W'(m_q);
	assign last_c    = (m_q == mend_q) || (n_q == PAIR_CNT_W'(MAX_PAIRS - 1));

	assign status.last_pair = last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		if (cmd.setup) begin
			steep_q <= steep_c;
			neg_q   <= min1 < min0;
			dzero_q <= dmaj_c == '0;
			dmaj_q  <= dmaj_c;
			num_q   <= DIV_W'(dmin_abs) << GFB;
			rem_q   <= '0;
			acc_q   <= $signed(ACC_W'(min0) << MIN_SHIFT);
			m_q     <= rsum0[COORD_W:SUBPIXEL_BITS];
			mend_q  <= rsum1[COORD_W:SUBPIXEL_BITS];
			n_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[COORD_W-1:0] : trial[COORD_W-1:0];
			num_q <= {num_q[DIV_W-2:0], trial_ge};
		end
		if (cmd.emit) begin
			pixel_x      <= steep_q ? minor_pix : major_pix;
			pixel_y      <= steep_q ? major_pix : minor_pix;
			steep        <= steep_q;
			first_level  <= LEVEL_W'(LEVEL_FULL) - LEVEL_W'(frac8);
			second_level <= LEVEL_W'(frac8);
			last         <= last_c;
			acc_q        <= acc_q + ACC_W'(grad);
			m_q          <= m_q + 1'b1;
			n_q          <= n_q + 1'b1;
		end
	end

endmodule

### bench/antialiased_line_rasterizer_test.sv
// self-checking testbench of the antialiased line rasterizer
module antialiased_line_rasterizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import aalr_pkg::*;

	localparam int GRID_BITS              = 6;
	localparam int SUBPIXEL_BITS          = 4;
	localparam int GRADIENT_FRACTION_BITS = 16;
	localparam int COORD_W                = GRID_BITS + SUBPIXEL_BITS;
	localparam int COORD_MAX              = 1015;
	localparam int RANDOM_SEGMENTS        = 250;
	localparam int DRAIN_CYCLES           = 100;
	localparam int CYCLE_LIMIT            = 400000;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		int                 gap;
	} segment_t;

	typedef struct {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    stp;
		logic [LEVEL_W-1:0]      lvl_first;
		logic [LEVEL_W-1:0]      lvl_second;
		logic                    lst;
	} pair_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [COORD_W-1:0]        start_x = '0;
	logic [COORD_W-1:0]        start_y = '0;
	logic [COORD_W-1:0]        end_x = '0;
	logic [COORD_W-1:0]        end_y = '0;
	logic                      valid;
	logic signed [PIX_W-1:0]   pixel_x;
	logic signed [PIX_W-1:0]   pixel_y;
	logic                      steep;
	logic [LEVEL_W-1:0]        first_level;
	logic [LEVEL_W-1:0]        second_level;
	logic                      last;

	segment_t segment_queue[$];
	pair_t    expected_pairs[$];
	segment_t current;
	bit       need_segment;
	bit       no_gaps;
	int       hold_cycles = 0;
	int       segments_total = 0;
	int       segments_taken = 0;
	int       pairs_outstanding = 0;
	int       pairs_checked = 0;
	int       zero_length = 0;
	int       steep_segments = 0;
	int       below_zero = 0;
	int       error_count = 0;
	int       cycle_count = 0;

	antialiased_line_rasterizer #(
		.GRID_BITS(GRID_BITS),
		.SUBPIXEL_BITS(SUBPIXEL_BITS),
		.GRADIENT_FRACTION_BITS(GRADIENT_FRACTION_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.valid(valid),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.steep(steep),
		.first_level(first_level),
		.second_level(second_level),
		.last(last)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h (pair %0d)",
				name, got, want, pairs_checked));
	endtask

	// walks the segment the way the block does and queues every pixel pair it yields
	function automatic void plot_segment(segment_t s);
		longint sx, sy, ex, ey, dx, dy, adx, ady;
		longint maj0, maj1, min0, dmaj, dmin, mag, grad, acc, m, mend, fl, frac, f8;
		longint half;
		bit is_steep;
		int n;
		pair_t p;
		sx = s.sx;
		sy = s.sy;
		ex = s.ex;
		ey = s.ey;
		dx = ex - sx;
		dy = ey - sy;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		is_steep = adx < ady;
		if (!is_steep) begin
			if (sx > ex) begin
				maj0 = ex; maj1 = sx; min0 = ey; dmaj = -dx; dmin = -dy;
			end else begin
				maj0 = sx; maj1 = ex; min0 = sy; dmaj = dx; dmin = dy;
			end
		end else begin
			if (sy > ey) begin
				maj0 = ey; maj1 = sy; min0 = ex; dmaj = -dy; dmin = -dx;
			end else begin
				maj0 = sy; maj1 = ey; min0 = sx; dmaj = dy; dmin = dx;
			end
		end
		if (dmaj == 0) begin
			grad = 0;
			zero_length++;
		end else begin
			mag = ((dmin < 0 ? -dmin : dmin) <<< GRADIENT_FRACTION_BITS) / dmaj;
			grad = dmin < 0 ? -mag : mag;
		end
		if (is_steep)
			steep_segments++;
		half = (1 << SUBPIXEL_BITS) >> 1;
		acc = min0 <<< (GRADIENT_FRACTION_BITS - SUBPIXEL_BITS);
		m = (maj0 + half) >>> SUBPIXEL_BITS;
		mend = (maj1 + half) >>> SUBPIXEL_BITS;
		n = 0;
		for (; m <= mend && n < MAX_PAIRS; m++) begin
			fl = acc >>> GRADIENT_FRACTION_BITS;
			frac = acc - (fl <<< GRADIENT_FRACTION_BITS);
			f8 = frac >>> (GRADIENT_FRACTION_BITS - LEVEL_FRAC_W);
			if (fl < 0)
				below_zero++;
			p.px = is_steep ? fl[PIX_W-1:0] : m[PIX_W-1:0];
			p.py = is_steep ? m[PIX_W-1:0] : fl[PIX_W-1:0];
			p.stp = is_steep;
			p.lvl_first = LEVEL_W'(LEVEL_FULL - f8);
			p.lvl_second = f8[LEVEL_W-1:0];
			p.lst = (m == mend) || (n == MAX_PAIRS - 1);
			expected_pairs.push_back(p);
			pairs_outstanding++;
			n++;
			acc += grad;
		end
	endfunction

	function automatic int clamp_coord(int v);
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	task automatic add_segment(int x0, int y0, int x1, int y1);
		segment_t s;
		s.sx = clamp_coord(x0);
		s.sy = clamp_coord(y0);
		s.ex = clamp_coord(x1);
		s.ey = clamp_coord(y1);
		s.gap = no_gaps ? 0 : $urandom_range(0, 3);
		segment_queue.push_back(s);
		segments_total++;
	endtask

	// driver: offers the next segment word once the gap drawn for it has passed
	always @(posedge clk) begin
		if (arst_n) begin
			need_segment = !start;
			if (start && !busy) begin
				plot_segment(current);
				segments_taken++;
				need_segment = 1'b1;
			end
			if (need_segment) begin
				if (segment_queue.size() != 0 && hold_cycles < segment_queue[0].gap) begin
					hold_cycles++;
					start <= 1'b0;
				end else if (segment_queue.size() != 0) begin
					current = segment_queue.pop_front();
					hold_cycles = 0;
					start_x <= current.sx;
					start_y <= current.sy;
					end_x <= current.ex;
					end_y <= current.ey;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every pixel pair word is compared with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch($sformatf("pixel pair (%0d,%0d) with none expected",
					pixel_x, pixel_y));
			end else begin
				check_field("pixel_x", LEVEL_W'(pixel_x), LEVEL_W'(expected_pairs[0].px));
				check_field("pixel_y", LEVEL_W'(pixel_y), LEVEL_W'(expected_pairs[0].py));
				check_field("steep", LEVEL_W'(steep), LEVEL_W'(expected_pairs[0].stp));
				check_field("first_level", first_level, expected_pairs[0].lvl_first);
				check_field("second_level", second_level, expected_pairs[0].lvl_second);
				check_field("last", LEVEL_W'(last), LEVEL_W'(expected_pairs[0].lst));
				void'(expected_pairs.pop_front());
				pairs_outstanding--;
				pairs_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still expected",
				cycle_count, pairs_outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int mode, x0, y0, x1, y1, d;
		no_gaps = 1'b0;
		// zero length, at two opposite corners of the grid and inside it
		add_segment(0, 0, 0, 0);
		add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		add_segment(517, 300, 517, 300);
		// full-length axis lines, both directions, giving the most pairs
		add_segment(0, 0, COORD_MAX, 0);
		add_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX);
		add_segment(0, 0, 0, COORD_MAX);
		add_segment(COORD_MAX, COORD_MAX, COORD_MAX, 0);
		// diagonals: equal deltas stay on the x axis
		add_segment(0, 0, COORD_MAX, COORD_MAX);
		add_segment(COORD_MAX, 0, 0, COORD_MAX);
		add_segment(100, 900, 900, 100);
		// shallow and steep, rising and falling, fractional endpoints
		add_segment(13, 40, 700, 301);
		add_segment(700, 301, 13, 40);
		add_segment(40, 13, 301, 700);
		add_segment(301, 700, 40, 13);
		add_segment(8, 7, 23, 9);
		add_segment(7, 8, 9, 23);
		// rounded major end overshoots so the minor floor drops below zero, plus a short one near the right edge
		add_segment(0, 16, 24, 0);
		add_segment(16, 0, 0, 24);
		add_segment(24, 0, 0, 16);
		add_segment(0, 24, 16, 0);
		add_segment(1000, 9, 1015, 0);
		// wide coordinates at the top of the grid
		add_segment(1015, 1000, 990, 1015);
		add_segment(1000, 1015, 1015, 990);

		for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
			no_gaps = (i >= 100 && i < 150) || (i >= 220 && i < 235);
			mode = $urandom_range(0, 5);
			x0 = $urandom_range(0, COORD_MAX);
			y0 = $urandom_range(0, COORD_MAX);
			d = $urandom_range(0, 1015);
			case (mode)
				0, 1: begin
					x1 = $urandom_range(0, COORD_MAX);
					y1 = $urandom_range(0, COORD_MAX);
				end
				2, 3: begin
					x1 = x0 + $urandom_range(0, 160) - 80;
					y1 = y0 + $urandom_range(0, 160) - 80;
				end
				4: begin
					case ($urandom_range(0, 3))
						0: begin x1 = x0 + d - 508; y1 = y0; end
						1: begin x1 = x0; y1 = y0 + d - 508; end
						2: begin x1 = x0 + d - 508; y1 = y0 + d - 508; end
						default: begin x1 = x0 + d - 508; y1 = y0 - d + 508; end
					endcase
				end
				default: begin
					// segments near a corner of the grid, where overshoot shows
					x0 = $urandom_range(0, 40);
					y0 = $urandom_range(0, 40);
					x1 = $urandom_range(0, 40);
					y1 = $urandom_range(0, 40);
					if ($urandom_range(0, 1)) begin
						x0 = COORD_MAX - x0; y0 = COORD_MAX - y0;
						x1 = COORD_MAX - x1; y1 = COORD_MAX - y1;
					end
				end
			endcase
			add_segment(x0, y0, x1, y1);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (segments_taken == segments_total);
		wait (pairs_outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		for (int i = 0; i < expected_pairs.size(); i++)
			report_mismatch($sformatf("expected pair (%0d,%0d) never came",
				expected_pairs[i].px, expected_pairs[i].py));
		$display("%0d segments drawn: %0d zero-length, %0d steep; %0d pixel pairs checked",
			segments_taken, zero_length, steep_segments, pairs_checked);
		$display("%0d pairs with a pixel below zero, %0d mismatches in %0d cycles",
			below_zero, error_count, cycle_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
